// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros for the RTL file that carries checks, indexed_list_store.
// ----------------------------------------------------------------------------
// Each macro expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ILS_ASSERT_SAME(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ILS_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== sv/ils_pkg.sv =====
// ----------------------------------------------------------------------------
// ils_pkg
// Types, codes and the microprogram of the indexed list store.
// ----------------------------------------------------------------------------
package ils_pkg;

	localparam int ILS_CAPACITY   = 64;
	localparam int ILS_DATA_WIDTH = 32;

	localparam int CMD_W = 3;
	localparam int VAL_W = 32;
	localparam int IDX_W = 16;
	localparam int ST_W  = 2;
	localparam int CNT_W = 7;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH    = 3'd0,
		CMD_REMOVE  = 3'd1,
		CMD_READ    = 3'd2,
		CMD_MODREAD = 3'd3,
		CMD_CLEAR   = 3'd4
	} cmd_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [VAL_W-1:0] value;
		logic [IDX_W-1:0] index;
	} in_item_t;

	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic [VAL_W-1:0] data;
		logic [CNT_W-1:0] count;
		logic             full_res;
		logic             empty_res;
	} out_item_t;

	// Datapath operations, one per microinstruction.
	typedef enum logic [3:0] {
		U_NOP,
		U_EMIT,
		U_LATCH,
		U_CHECK,
		U_PUSH,
		U_RM_INIT,
		U_RM_RD,
		U_RM_WR,
		U_DEC,
		U_RD_ADDR,
		U_DIV_INIT,
		U_DIV_STEP,
		U_MOD_ADDR,
		U_CAPTURE,
		U_CLEAR
	} uop_t;

	// Branch conditions. A false condition falls through to the next step.
	typedef enum logic [2:0] {
		C_NONE,
		C_ALWAYS,
		C_NO_INPUT,
		C_OUT_BUSY,
		C_SHIFT_DONE,
		C_DIV_MORE,
		C_DISPATCH
	} cond_t;

	typedef logic [3:0] step_t;

	localparam step_t S_RESULT   = 4'd0;
	localparam step_t S_IDLE     = 4'd1;
	localparam step_t S_CHECK    = 4'd2;
	localparam step_t S_PUSH     = 4'd3;
	localparam step_t S_RM_INIT  = 4'd4;
	localparam step_t S_RM_RD    = 4'd5;
	localparam step_t S_RM_WR    = 4'd6;
	localparam step_t S_RM_DEC   = 4'd7;
	localparam step_t S_RD_ADDR  = 4'd8;
	localparam step_t S_MOD_INIT = 4'd9;
	localparam step_t S_MOD_STEP = 4'd10;
	localparam step_t S_MOD_ADDR = 4'd11;
	localparam step_t S_CAPTURE  = 4'd12;
	localparam step_t S_CLEAR    = 4'd13;

	typedef struct packed {
		uop_t  uop;
		cond_t cond;
		step_t target;
	} uword_t;

	// Status and condition flags the datapath hands to the sequencer.
	typedef struct packed {
		logic             in_valid;
		logic             out_busy;
		logic             shift_done;
		logic             div_more;
		logic             check_ok;
		logic [CMD_W-1:0] cmd;
	} dp_flags_t;

	function automatic uword_t ils_rom(input step_t pc);
		uword_t w;
		case (pc)
			S_RESULT:   w = '{U_EMIT,     C_OUT_BUSY,   S_RESULT};
			S_IDLE:     w = '{U_LATCH,    C_NO_INPUT,   S_IDLE};
			S_CHECK:    w = '{U_CHECK,    C_DISPATCH,   S_RESULT};
			S_PUSH:     w = '{U_PUSH,     C_ALWAYS,     S_RESULT};
			S_RM_INIT:  w = '{U_RM_INIT,  C_NONE,       S_RESULT};
			S_RM_RD:    w = '{U_RM_RD,    C_SHIFT_DONE, S_RM_DEC};
			S_RM_WR:    w = '{U_RM_WR,    C_ALWAYS,     S_RM_RD};
			S_RM_DEC:   w = '{U_DEC,      C_ALWAYS,     S_RESULT};
			S_RD_ADDR:  w = '{U_RD_ADDR,  C_ALWAYS,     S_CAPTURE};
			S_MOD_INIT: w = '{U_DIV_INIT, C_NONE,       S_RESULT};
			S_MOD_STEP: w = '{U_DIV_STEP, C_DIV_MORE,   S_MOD_STEP};
			S_MOD_ADDR: w = '{U_MOD_ADDR, C_NONE,       S_RESULT};
			S_CAPTURE:  w = '{U_CAPTURE,  C_ALWAYS,     S_RESULT};
			S_CLEAR:    w = '{U_CLEAR,    C_ALWAYS,     S_RESULT};
			default:    w = '{U_NOP,      C_ALWAYS,     S_IDLE};
		endcase
		return w;
	endfunction

	// Entry point of each command; a failed check goes straight to the result.
	function automatic step_t ils_dispatch(input logic [CMD_W-1:0] cmd, input logic ok);
		step_t s;
		if (!ok) begin
			s = S_RESULT;
		end else begin
			case (cmd)
				CMD_PUSH:    s = S_PUSH;
				CMD_REMOVE:  s = S_RM_INIT;
				CMD_READ:    s = S_RD_ADDR;
				CMD_MODREAD: s = S_MOD_INIT;
				CMD_CLEAR:   s = S_CLEAR;
				default:     s = S_RESULT;
			endcase
		end
		return s;
	endfunction

endpackage

// ===== sv/ils_seq.sv =====
// ----------------------------------------------------------------------------
// ils_seq
// Step counter and microprogram lookup with conditional branches.
// ----------------------------------------------------------------------------
module ils_seq import ils_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  dp_flags_t flags,
	output uop_t      uop
);

	step_t  pc_q;
	step_t  pc_next;
	uword_t uw;

	always_comb begin
		uw  = ils_rom(pc_q);
		uop = uw.uop;
		case (uw.cond)
			C_NONE:       pc_next = pc_q + 4'd1;
			C_ALWAYS:     pc_next = uw.target;
			C_NO_INPUT:   pc_next = flags.in_valid ? pc_q + 4'd1 : uw.target;
			C_OUT_BUSY:   pc_next = flags.out_busy ? uw.target : pc_q + 4'd1;
			C_SHIFT_DONE: pc_next = flags.shift_done ? uw.target : pc_q + 4'd1;
			C_DIV_MORE:   pc_next = flags.div_more ? uw.target : pc_q + 4'd1;
			C_DISPATCH:   pc_next = ils_dispatch(flags.cmd, flags.check_ok);
			default:      pc_next = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end

endmodule

// ===== sv/ils_dp.sv =====
// ----------------------------------------------------------------------------
// ils_dp
// Datapath: entry memory, count, bound checks, remainder unit, result register.
// ----------------------------------------------------------------------------
module ils_dp import ils_pkg::*; #(
	parameter int CAPACITY   = ILS_CAPACITY,
	parameter int DATA_WIDTH = ILS_DATA_WIDTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  uop_t      uop,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data,
	output dp_flags_t flags
);

	localparam int AW  = $clog2(CAPACITY);
	localparam int CW  = $clog2(CAPACITY + 1);
	localparam int DCW = $clog2(IDX_W);

	logic [DATA_WIDTH-1:0] mem_q [CAPACITY];
	logic [DATA_WIDTH-1:0] rdata_q;

	logic [CMD_W-1:0] cmd_q;
	logic [VAL_W-1:0] value_q;
	logic [IDX_W-1:0] index_q;
	logic [VAL_W-1:0] data_q;
	status_t          status_q;
	logic [CW-1:0]    count_q;
	logic [AW-1:0]    ptr_q;
	logic [CW-1:0]    rem_q;
	logic [DCW-1:0]   div_cnt_q;
	logic             out_valid_q;
	out_item_t        out_q;

	logic                  empty;
	logic                  full;
	logic                  out_busy;
	logic [CW:0]           ptr_next;
	logic [CW:0]           trial;
	logic [CW:0]           rem_next;
	status_t               chk_status;
	logic                  mem_we;
	logic [AW-1:0]         waddr;
	logic [DATA_WIDTH-1:0] wdata;
	logic [AW-1:0]         raddr;

	assign empty    = (count_q == '0);
	assign full     = (count_q == CW'(CAPACITY));
	assign out_busy = out_valid_q && !out_ready;
	assign in_ready = (uop == U_LATCH);

	// Remove moves entry ptr+1 down to ptr until ptr+1 reaches the count.
	assign ptr_next = (CW+1)'(ptr_q) + (CW+1)'(1);

	// Restoring remainder, one index bit per step, most significant first.
	// The remainder stays below the count, so the trial fits in one extra bit.
	assign trial    = {rem_q, index_q[IDX_W-1]};
	assign rem_next = (trial >= {1'b0, count_q}) ? trial - {1'b0, count_q} : trial;

	always_comb begin
		chk_status = ST_OK;
		case (cmd_q)
			CMD_PUSH: begin
				if (full) chk_status = ST_FULL;
			end
			CMD_REMOVE, CMD_READ: begin
				if (empty) begin
					chk_status = ST_EMPTY;
				end else if (index_q >= IDX_W'(count_q)) begin
					chk_status = ST_RANGE;
				end
			end
			CMD_MODREAD, CMD_CLEAR: begin
				if (empty) chk_status = ST_EMPTY;
			end
			default: chk_status = ST_OK;
		endcase
	end

	always_comb begin
		mem_we = 1'b0;
		waddr  = ptr_q;
		wdata  = rdata_q;
		case (uop)
			U_PUSH: begin
				mem_we = 1'b1;
				waddr  = count_q[AW-1:0];
				wdata  = DATA_WIDTH'(value_q);
			end
			U_RM_WR: begin
				mem_we = 1'b1;
			end
			default: mem_we = 1'b0;
		endcase
	end

	always_comb begin
		case (uop)
			U_RM_RD:    raddr = ptr_next[AW-1:0];
			U_RD_ADDR:  raddr = index_q[AW-1:0];
			U_MOD_ADDR: raddr = rem_q[AW-1:0];
			default:    raddr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	always_ff @(posedge clk) begin
		case (uop)
			U_LATCH: begin
				if (in_valid) begin
					cmd_q   <= in_data.cmd;
					value_q <= in_data.value;
					index_q <= in_data.index;
					data_q  <= '0;
				end
			end
			U_CHECK:    status_q <= chk_status;
			U_RM_INIT:  ptr_q <= index_q[AW-1:0];
			U_RM_WR:    ptr_q <= ptr_q + AW'(1);
			U_DIV_INIT: begin
				rem_q     <= '0;
				div_cnt_q <= '0;
			end
			U_DIV_STEP: begin
				rem_q     <= rem_next[CW-1:0];
				index_q   <= index_q << 1;
				div_cnt_q <= div_cnt_q + DCW'(1);
			end
			U_CAPTURE:  data_q <= VAL_W'(rdata_q);
			U_EMIT: begin
				if (!out_busy) begin
					out_q.status    <= status_q;
					out_q.data      <= data_q;
					out_q.count     <= CNT_W'(count_q);
					out_q.full_res  <= full;
					out_q.empty_res <= empty;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (uop)
				U_PUSH:  count_q <= count_q + CW'(1);
				U_DEC:   count_q <= count_q - CW'(1);
				U_CLEAR: count_q <= '0;
				default: ;
			endcase
			if (uop == U_EMIT && !out_busy) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		flags.in_valid   = in_valid;
		flags.out_busy   = out_busy;
		flags.shift_done = (ptr_next >= (CW+1)'(count_q));
		flags.div_more   = (div_cnt_q != DCW'(IDX_W - 1));
		flags.check_ok   = (chk_status == ST_OK);
		flags.cmd        = cmd_q;
	end

endmodule

// ===== sv/indexed_list_store.sv =====
// ----------------------------------------------------------------------------
// indexed_list_store
// Bounded array list with push, remove, read, modulo read and clear.
// ----------------------------------------------------------------------------
// One command is worked at a time by a microcoded sequencer over a single
// entry memory with one write and one registered read port. Each command
// gives exactly one result. A rejected or unknown command goes from the
// check straight to the result; push writes the new entry and clear empties
// the list; read addresses the memory, then captures the data; modulo read
// works out one remainder bit per cycle over the 16 index bits, then reads;
// remove moves each later entry down, and each moved entry needs one read
// and one write on the memory port. A new command is taken in the cycle
// after its predecessor's result is loaded, even while it waits for transfer.
module indexed_list_store import ils_pkg::*; #(
	parameter int CAPACITY   = ILS_CAPACITY,
	parameter int DATA_WIDTH = ILS_DATA_WIDTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	`include "assert_macros.svh"

	uop_t      uop;
	dp_flags_t flags;

	ils_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.uop    (uop)
	);

	ils_dp #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.uop       (uop),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.flags     (flags)
	);

	// A command is never taken in two consecutive cycles.
	`ILS_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready, "command taken while busy")
	// Full and empty cannot both be reported.
	`ILS_ASSERT_SAME(a_flags_excl, out_valid, !(out_data.full_res && out_data.empty_res), "full and empty together")
	// Read data is only returned by a successful command.
	`ILS_ASSERT_SAME(a_data_ok, out_valid && out_data.data != '0, out_data.status == ST_OK, "data on failed command")
	// An empty status always leaves the list empty.
	`ILS_ASSERT_SAME(a_empty_stat, out_valid && out_data.status == ST_EMPTY, out_data.empty_res, "empty status on non-empty list")

endmodule
